[rtl/shmm_pkg.sv]
// shared types, character constants and text helpers of the hex memory monitor
`default_nettype none

package shmm_pkg;

  // ascii codes used by the parser and the emitter
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UP_D  = 8'h44;
  localparam logic [7:0] CH_LO_D  = 8'h64;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_LO_E  = 8'h65;
  localparam logic [3:0] NIB_MASK = 4'hF;

  localparam int unsigned ERR_LEN = 34;
  localparam logic [0:ERR_LEN-1][7:0] ERR_TEXT =
    {"Bitte nur D/d oder E/e eingeben!", CH_CR, CH_LF};

  localparam logic [15:0][7:0] HEX_DIGITS = "FEDCBA9876543210";

  // job queue depth
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  typedef enum logic [2:0] {
    PH_CMD   = 3'd0,
    PH_RETRY = 3'd1,
    PH_SEP1  = 3'd2,
    PH_ADDR  = 3'd3,
    PH_SEP2  = 3'd4,
    PH_DHI   = 3'd5,
    PH_DLO   = 3'd6
  } phase_e;

  // what follows the optional leading character of a job
  typedef enum logic [1:0] {
    T_NONE  = 2'd0,
    T_ERR   = 2'd1,
    T_DISP  = 2'd2,
    T_WRITE = 2'd3
  } tail_e;

  typedef struct packed {
    logic        echo;
    logic [7:0]  ch;
    tail_e       tail;
    logic [31:0] addr;
    logic [7:0]  data;
  } shmm_job_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= "0" && c <= "9") v = 4'(c - "0");
    else if (c >= "A" && c <= "F") v = 4'(c - "A" + 8'd10);
    else if (c >= "a" && c <= "f") v = 4'(c - "a" + 8'd10);
    return v;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return HEX_DIGITS[n & NIB_MASK];
  endfunction

  // index of the final tail character
  function automatic logic [5:0] tail_last(input tail_e t);
    logic [5:0] n;
    unique case (t)
      T_ERR:   n = 6'(ERR_LEN - 1);
      T_DISP:  n = 6'd15;
      T_WRITE: n = 6'd1;
      default: n = 6'd0;
    endcase
    return n;
  endfunction

  // display line: CR LF, eight address digits, ": ", two data digits, CR LF
  function automatic logic [7:0] disp_char(input logic [5:0] idx, input logic [31:0] a,
                                           input logic [7:0] b);
    logic [7:0] ch;
    unique case (idx)
      6'd0:    ch = CH_CR;
      6'd1:    ch = CH_LF;
      6'd2:    ch = hex_char(a[31:28]);
      6'd3:    ch = hex_char(a[27:24]);
      6'd4:    ch = hex_char(a[23:20]);
      6'd5:    ch = hex_char(a[19:16]);
      6'd6:    ch = hex_char(a[15:12]);
      6'd7:    ch = hex_char(a[11:8]);
      6'd8:    ch = hex_char(a[7:4]);
      6'd9:    ch = hex_char(a[3:0]);
      6'd10:   ch = CH_COLON;
      6'd11:   ch = CH_SPACE;
      6'd12:   ch = hex_char(b[7:4]);
      6'd13:   ch = hex_char(b[3:0]);
      6'd14:   ch = CH_CR;
      6'd15:   ch = CH_LF;
      default: ch = CH_SPACE;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

[rtl/shmm_if.sv]
// valid/ready channel interfaces for received and transmitted characters
`default_nettype none

interface shmm_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_char;

  modport source (output valid, output rx_char, input ready);
  modport sink   (input valid, input rx_char, output ready);
endinterface

interface shmm_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_char;
  logic       last_of_run;

  modport source (output valid, output tx_char, output last_of_run, input ready);
  modport sink   (input valid, input tx_char, input last_of_run, output ready);
endinterface

`default_nettype wire

[rtl/shmm_front.sv]
// command parser: takes received characters and queues output jobs
`default_nettype none

module shmm_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  shmm_rx_if.sink            rx_i,
  input  wire logic          init_done_i,
  input  wire logic          full_i,
  output logic               push_o,
  output shmm_pkg::shmm_job_t job_o
);
  import shmm_pkg::*;

  phase_e      phase_q, phase_d;
  logic        is_edit_q, is_edit_d;
  logic [3:0]  digit_count_q, digit_count_d;
  logic [31:0] addr_q, addr_d;
  logic [3:0]  hi_q, hi_d;
  logic        accept;
  logic        job_vld;
  logic [7:0]  c;
  logic [3:0]  hv;
  logic        cmd_ok, cmd_edit;
  logic [31:0] shifted;

  assign rx_i.ready = init_done_i & ~full_i;
  assign accept     = rx_i.valid & rx_i.ready;
  assign push_o     = accept & job_vld;

  always_comb begin
    c        = rx_i.rx_char;
    hv       = hex_value(c);
    cmd_edit = (c == CH_UP_E) || (c == CH_LO_E);
    cmd_ok   = cmd_edit || (c == CH_UP_D) || (c == CH_LO_D);
    shifted  = {addr_q[27:0], hv};

    phase_d       = phase_q;
    is_edit_d     = is_edit_q;
    digit_count_d = digit_count_q;
    addr_d        = addr_q;
    hi_d          = hi_q;
    job_vld       = 1'b0;
    job_o         = '{echo: 1'b1, ch: c, tail: T_NONE, addr: addr_q, data: {hi_q, hv}};

    unique case (phase_q)
      PH_RETRY: begin
        job_vld = 1'b1;
        if (cmd_ok) begin
          is_edit_d = cmd_edit;
          phase_d   = PH_SEP1;
        end else begin
          job_o.tail = T_ERR;
        end
      end
      PH_SEP1: begin
        job_vld       = 1'b1;
        job_o.ch      = CH_SPACE;
        digit_count_d = 4'd0;
        addr_d        = 32'd0;
        phase_d       = PH_ADDR;
      end
      PH_ADDR: begin
        job_vld = 1'b1;
        if (c != CH_CR) begin
          addr_d        = shifted;
          digit_count_d = digit_count_q + 4'd1;
          job_o.addr    = shifted;
        end
        // a CR or the eighth digit closes the address
        if (c == CH_CR || digit_count_q == 4'd7) begin
          if (is_edit_q) begin
            phase_d = PH_SEP2;
          end else begin
            job_o.tail = T_DISP;
            phase_d    = PH_CMD;
          end
        end
      end
      PH_SEP2: begin
        job_vld  = 1'b1;
        job_o.ch = CH_SPACE;
        phase_d  = PH_DHI;
      end
      PH_DHI: begin
        job_vld = 1'b1;
        hi_d    = hv;
        phase_d = PH_DLO;
      end
      PH_DLO: begin
        job_vld    = 1'b1;
        job_o.tail = T_WRITE;
        phase_d    = PH_CMD;
      end
      default: begin
        // waiting for a command; the unused code lands here too
        if (cmd_ok) begin
          is_edit_d = cmd_edit;
          phase_d   = PH_SEP1;
        end else begin
          job_vld    = 1'b1;
          job_o.echo = 1'b0;
          job_o.tail = T_ERR;
          phase_d    = PH_RETRY;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_CMD;
      is_edit_q     <= 1'b0;
      digit_count_q <= 4'd0;
      addr_q        <= 32'd0;
      hi_q          <= 4'd0;
    end else if (accept) begin
      phase_q       <= phase_d;
      is_edit_q     <= is_edit_d;
      digit_count_q <= digit_count_d;
      addr_q        <= addr_d;
      hi_q          <= hi_d;
    end
  end

endmodule

`default_nettype wire

[rtl/shmm_fifo.sv]
// two-entry job queue between parser and emitter
`default_nettype none

module shmm_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire shmm_pkg::shmm_job_t  job_i,
  input  wire logic                 pop_i,
  output shmm_pkg::shmm_job_t       job_o,
  output logic                      empty_o,
  output logic                      full_o
);
  import shmm_pkg::*;

  shmm_job_t            entry_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_q, rd_q;
  logic [Q_CNT_W-1:0]   cnt_q;

  assign empty_o = (cnt_q == Q_CNT_W'(0));
  assign full_o  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign job_o   = entry_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + Q_PTR_W'(1);
      if (pop_i)  rd_q <= rd_q + Q_PTR_W'(1);
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + Q_CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - Q_CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/shmm_back.sv]
// emitter: runs queued jobs, owns the byte store and the output register
`default_nettype none

module shmm_back #(
  parameter int unsigned ADDR_BITS = 10
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire shmm_pkg::shmm_job_t  job_i,
  input  wire logic                 empty_i,
  output logic                      pop_o,
  output logic                      init_done_o,
  shmm_tx_if.source                 tx_o
);
  import shmm_pkg::*;

  localparam longint unsigned STORE_DEPTH = 64'd1 << ADDR_BITS;

  logic [7:0]        store [STORE_DEPTH];
  logic [ADDR_BITS:0] clr_q;
  logic [7:0]        rd_q;

  logic        busy_q, echo_pend_q;
  logic [7:0]  ch_q;
  tail_e       tail_q;
  logic [5:0]  idx_q;
  logic [31:0] addr_q;
  logic        out_vld_q, out_last_q;
  logic [7:0]  out_ch_q;

  logic        adv, fin, gen_last, clearing;
  logic [7:0]  gen_ch;

  assign clearing    = ~clr_q[ADDR_BITS];
  assign init_done_o = clr_q[ADDR_BITS];

  always_comb begin
    if (echo_pend_q) begin
      gen_ch   = ch_q;
      gen_last = (tail_q == T_NONE);
    end else begin
      unique case (tail_q)
        T_ERR:   gen_ch = ERR_TEXT[idx_q];
        T_DISP:  gen_ch = disp_char(idx_q, addr_q, rd_q);
        T_WRITE: gen_ch = (idx_q == 6'd0) ? CH_CR : CH_LF;
        default: gen_ch = ch_q;
      endcase
      gen_last = (idx_q == tail_last(tail_q));
    end
    adv   = busy_q & (~out_vld_q | tx_o.ready);
    fin   = adv & gen_last;
    pop_o = ~empty_i & init_done_o & (~busy_q | fin);
  end

  assign tx_o.valid       = out_vld_q;
  assign tx_o.tx_char     = out_ch_q;
  assign tx_o.last_of_run = out_last_q;

  // store: clearing sweep after reset, then in-order writes and reads
  always_ff @(posedge clk_i) begin
    if (clearing) begin
      store[clr_q[ADDR_BITS-1:0]] <= 8'd0;
    end else if (pop_o && job_i.tail == T_WRITE) begin
      store[job_i.addr[ADDR_BITS-1:0]] <= job_i.data;
    end
    if (pop_o) rd_q <= store[job_i.addr[ADDR_BITS-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ch_q   <= job_i.ch;
      addr_q <= job_i.addr;
    end
    if (adv) begin
      out_ch_q   <= gen_ch;
      out_last_q <= gen_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      busy_q      <= 1'b0;
      echo_pend_q <= 1'b0;
      tail_q      <= T_NONE;
      idx_q       <= 6'd0;
      out_vld_q   <= 1'b0;
    end else begin
      if (clearing) clr_q <= clr_q + (ADDR_BITS+1)'(1);
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (tx_o.ready) begin
        out_vld_q <= 1'b0;
      end
      // a new job takes over in the cycle its predecessor ends
      if (pop_o) begin
        busy_q      <= 1'b1;
        echo_pend_q <= job_i.echo;
        tail_q      <= job_i.tail;
        idx_q       <= 6'd0;
      end else if (adv) begin
        if (echo_pend_q) echo_pend_q <= 1'b0;
        else idx_q <= idx_q + 6'd1;
        if (gen_last) busy_q <= 1'b0;
      end
    end
  end

  a_no_pop_while_clearing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> init_done_o)
    else $error("job taken during store clearing");

  a_bare_job_has_echo : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && tail_q == T_NONE) |-> echo_pend_q)
    else $error("active job has neither echo nor tail");

  a_idx_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !echo_pend_q) |-> (idx_q <= tail_last(tail_q)))
    else $error("tail index past end of text");

  a_pop_after_write_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !gen_last) |=> busy_q)
    else $error("job ended before its last character");

endmodule

`default_nettype wire

[rtl/serial_hex_memory_monitor.sv]
// top level of the character-driven hex memory monitor
`default_nettype none

// Takes one received character per rx transfer and returns the characters to
// send back on tx, each with last_of_run set on the final character caused by
// that input (a valid command letter causes none unless a bad one came before).
// D/d displays and E/e edits a byte of a local store of 2**ADDR_BITS bytes,
// addressed by the typed 32-bit address modulo its size. After reset the store
// is cleared by a sweep over all its addresses, during which rx is not ready.
// Each input yields at most one job; a two-entry job queue lets the parser keep
// taking characters while the emitter works. The emitter sends one character
// per cycle from its output register while tx is ready; an input has 1 to 35
// result characters, e.g. 17 for a display, 35 for an echoed bad retry. The
// first character of a job passes through the job queue, the emitter's job
// registers and its output register. The sustained rate is set by the
// emitter's one-character-per-cycle sequencer, stalled when tx is not ready.

module serial_hex_memory_monitor #(
  parameter int unsigned ADDR_BITS = 10
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  shmm_rx_if.sink   rx_i,
  shmm_tx_if.source tx_o
);
  import shmm_pkg::*;

  shmm_job_t push_job, head_job;
  logic      push, pop, empty, full, init_done;

  // parser: phase tracking, address and data digit collection
  shmm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_i),
    .init_done_i (init_done),
    .full_i      (full),
    .push_o      (push),
    .job_o       (push_job)
  );

  // decouples parsing from character emission
  shmm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .empty_o (empty),
    .full_o  (full)
  );

  // emitter: store access, text sequencing, tx output register
  shmm_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .empty_i     (empty),
    .pop_o       (pop),
    .init_done_o (init_done),
    .tx_o        (tx_o)
  );

endmodule

`default_nettype wire
